// ===== rtl/ca_1d_cell_update_unit_defines.svh =====
// assertion macros shared by the cellular automaton rtl
`ifndef CA_1D_CELL_UPDATE_UNIT_DEFINES_SVH
`define CA_1D_CELL_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CA1D_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CA1D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ca1d_pkg.sv =====
// shared constants and types for the cellular automaton cell update unit
package ca1d_pkg;

  localparam int ROW_MAX    = 64;
  localparam int MAX_RADIUS = 2;

  localparam int CELL_AW    = $clog2(ROW_MAX);
  localparam int LEN_W      = $clog2(ROW_MAX + 1);
  localparam int RAD_W      = 2;
  localparam int RULE_W     = 32;
  localparam int WIN_W      = 2 * MAX_RADIUS + 1;
  localparam int CNT_W      = $clog2(2 * MAX_RADIUS + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH = 2'd0,
    REG_RADIUS     = 2'd1,
    REG_RULE_BITS  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BACK,
    ST_READ,
    ST_CAPTURE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    ADDR_HOLD,
    ADDR_LOAD,
    ADDR_DEC,
    ADDR_INC
  } addr_op_t;

  typedef struct packed {
    addr_op_t           op;
    logic [CELL_AW-1:0] load_val;
  } addr_cmd_t;

endpackage

// ===== rtl/ca_1d_cell_update_unit.sv =====
// top level of the one-dimensional binary cellular automaton cell update unit
// Keeps a circular row of up to ROW_MAX binary cells in a ram. A write request
// stores one cell. An evaluate request walks the window of 2*r+1 cells around
// the position (r is the effective radius) with one shared wrap-around address
// stepper: it steps back to the leftmost cell, then reads each window cell
// through a read state and a capture state for the registered ram read, then
// forms the result in the finish state. An out-of-range position goes straight
// to the finish state. The input is stalled while an evaluation is in progress;
// a finished result sits in an output register, and the final step waits only
// while that register is full and out_stall is high. Cells read as zero until
// written; no clearing pass is needed.
`include "ca_1d_cell_update_unit_defines.svh"

module ca_1d_cell_update_unit
  import ca1d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [CELL_AW-1:0]    cell_index,
  input  logic                  cell_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  new_state,
  output logic                  position_error
);

  // configuration
  logic [LEN_W-1:0]  row_length;
  logic [RAD_W-1:0]  radius;
  logic [RULE_W-1:0] rule_bits;
  logic [LEN_W-1:0]  len_eff;
  logic [RAD_W-1:0]  rad_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= LEN_W'(ROW_MAX);
      radius     <= RAD_W'(1);
      rule_bits  <= RULE_W'(30);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_LENGTH: row_length <= cfg_data[LEN_W-1:0];
        REG_RADIUS:     radius     <= cfg_data[RAD_W-1:0];
        REG_RULE_BITS:  rule_bits  <= cfg_data[RULE_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = (row_length > LEN_W'(ROW_MAX)) ? LEN_W'(ROW_MAX) : row_length;
  assign rad_eff = (radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;

  // sequencer
  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   cnt;
  logic [WIN_W-1:0]   win;
  logic               err;
  logic               in_acc;
  logic               out_free;
  logic               pos_bad;
  logic [CNT_W-1:0]   span;
  addr_cmd_t          acmd;
  logic [CELL_AW-1:0] addr;
  logic               ram_we;
  logic               ram_re;
  logic [0:0]         ram_rdata;
  logic [ROW_MAX-1:0] cell_vld;
  logic               rd_vld;
  logic               rd_bit;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pos_bad  = LEN_W'(cell_index) >= len_eff;
  assign span     = CNT_W'({rad_eff, 1'b0});
  assign rd_bit   = ram_rdata[0] & rd_vld;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && opcode == OP_EVAL) begin
          if (pos_bad) begin
            state_next = ST_FINISH;
          end else if (rad_eff == '0) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_BACK;
          end
        end
      end
      ST_BACK: begin
        if (cnt == CNT_W'(1)) begin
          state_next = ST_READ;
        end
      end
      ST_READ:    state_next = ST_CAPTURE;
      ST_CAPTURE: state_next = (cnt == '0) ? ST_FINISH : ST_READ;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != ST_IDLE);
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    acmd.op       = ADDR_HOLD;
    acmd.load_val = cell_index;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          ram_we  = (opcode == OP_WRITE);
          acmd.op = (opcode == OP_EVAL) ? ADDR_LOAD : ADDR_HOLD;
        end
      end
      ST_BACK:    acmd.op = ADDR_DEC;
      ST_READ:    ram_re  = 1'b1;
      ST_CAPTURE: acmd.op = (cnt == '0) ? ADDR_HOLD : ADDR_INC;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window walk counter, window shift register and error flag
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cnt <= (rad_eff == '0) ? '0 : CNT_W'(rad_eff);
        win <= '0;
        err <= pos_bad;
      end
      ST_BACK: begin
        cnt <= (cnt == CNT_W'(1)) ? span : cnt - CNT_W'(1);
      end
      ST_CAPTURE: begin
        win <= {win[WIN_W-2:0], rd_bit};
        if (cnt != '0) begin
          cnt <= cnt - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // per-cell written flags, cleared at reset; an unwritten cell reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_vld <= '0;
    end else if (ram_we) begin
      cell_vld[cell_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld <= cell_vld[addr];
    end
  end

  ca1d_addr_unit u_addr (
    .clk  (clk),
    .rst  (rst),
    .cmd  (acmd),
    .len  (len_eff),
    .addr (addr)
  );

  ca1d_ram #(
    .WIDTH (1),
    .DEPTH (ROW_MAX)
  ) u_row (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cell_index),
    .wdata (cell_value),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      new_state      <= err ? 1'b0 : rule_bits[win];
      position_error <= err;
    end
  end

  `CA1D_ASSERT_SAME(a_result_from_finish, clk, rst,
    $rose(out_valid),
    $past(state == ST_FINISH), "result appeared without a finished evaluation")
  `CA1D_ASSERT_NEXT(a_write_one_cycle, clk, rst,
    in_acc && opcode == OP_WRITE,
    state == ST_IDLE, "write request did not complete in one cycle")
  `CA1D_ASSERT_SAME(a_error_zero_state, clk, rst,
    out_valid && position_error,
    !new_state, "error result carries a nonzero state")

endmodule

// ===== rtl/ca1d_ram.sv =====
// generic single-write, single-read ram with registered read data
module ca1d_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ca1d_addr_unit.sv =====
// shared address register with wrap-around step over the circular row
`include "ca_1d_cell_update_unit_defines.svh"

module ca1d_addr_unit
  import ca1d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  addr_cmd_t          cmd,
  input  logic [LEN_W-1:0]   len,
  output logic [CELL_AW-1:0] addr
);

  logic [CELL_AW-1:0] addr_next;
  logic [LEN_W-1:0]   last;
  logic [LEN_W-1:0]   addr_ext;

  assign last     = len - LEN_W'(1);
  assign addr_ext = LEN_W'(addr);

  always_comb begin
    case (cmd.op)
      ADDR_HOLD: addr_next = addr;
      ADDR_LOAD: addr_next = cmd.load_val;
      ADDR_DEC:  addr_next = (addr == '0) ? last[CELL_AW-1:0] : addr - CELL_AW'(1);
      ADDR_INC:  addr_next = (addr_ext == last) ? '0 : addr + CELL_AW'(1);
      default:   addr_next = addr;
    endcase
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
  end

  `CA1D_ASSERT_NEXT(a_step_in_range, clk, rst,
    (cmd.op == ADDR_INC || cmd.op == ADDR_DEC) && addr_ext < len,
    addr_ext < $past(len), "address left the row after a step")
  `CA1D_ASSERT_NEXT(a_inc_wraps, clk, rst,
    cmd.op == ADDR_INC && addr_ext == last,
    addr == '0, "increment from the last cell did not wrap to zero")
  `CA1D_ASSERT_NEXT(a_load_takes, clk, rst,
    cmd.op == ADDR_LOAD,
    addr == $past(cmd.load_val), "address load lost")

endmodule
